>>> src/ncp_pkg.sv
// Package: widths, types and the per-cell record of the normalized cross product pipeline.
package ncp_pkg;

	localparam int COORD_WIDTH      = 24;
	localparam int NORMAL_FRAC_BITS = 30;
	localparam int N_W              = 32;

	localparam int HALF_W    = COORD_WIDTH;
	localparam int MAG_W     = 2 * COORD_WIDTH;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int LEN_W     = SQ_W + 2;
	localparam int RES_W     = SQ_W + 2 * NORMAL_FRAC_BITS;
	localparam int PROD_W    = LEN_W + NORMAL_FRAC_BITS + 1;
	localparam int DLT_W     = LEN_W + 2 * NORMAL_FRAC_BITS + 2;
	localparam int Q_W       = NORMAL_FRAC_BITS + 1;
	localparam int NUM_CELLS = NORMAL_FRAC_BITS + 1;
	localparam int BIT_W     = $clog2(NORMAL_FRAC_BITS + 1);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [MAG_W-1:0]  mag_t;
	typedef logic [SQ_W-1:0]   sq_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [RES_W-1:0]  res_t;
	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [Q_W-1:0]    q_t;
	typedef logic [BIT_W-1:0]  bit_idx_t;

	// One transaction as it moves down the row of quotient cells.
	typedef struct packed {
		logic            valid;
		logic            zero;
		len_t            len2;
		res_t  [2:0]     r;
		prod_t [2:0]     p;
		q_t    [2:0]     q;
		logic  [2:0]     neg;
	} cell_t;

endpackage

>>> src/normalized_cross_product.sv
// Top level: unit normal of the cross product of two fixed-point 3D vectors.
//
// Command channel: a transaction is taken at each rising edge with start high
// and busy low. busy is always low, so a new vector pair may enter every cycle.
// Inputs a_* and b_* are signed Q8.16; outputs n_* are signed Q2.30, each the
// exact quotient c_i / |c| of the cross product c = a x b, rounded toward zero.
// A zero cross product gives the zero vector with zero_length set.
//
// From accept to the done strobe a transaction passes four front-end stages
// (products, differences, partial squares, squared length), a row of 31
// quotient cells that each settle one bit of all three components, and one
// output register. Throughput is one transaction per cycle, set by the fully
// pipelined cell row.
//
// done is high for exactly one cycle with the result; the receiver must take
// it then, since it cannot hold results off. Reset clears every valid bit, so
// nothing in flight survives it and no strobe follows until new transactions.
module normalized_cross_product import ncp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  coord_t                a_x,
	input  coord_t                a_y,
	input  coord_t                a_z,
	input  coord_t                b_x,
	input  coord_t                b_y,
	input  coord_t                b_z,
	output logic                  done,
	output logic signed [N_W-1:0] n_x,
	output logic signed [N_W-1:0] n_y,
	output logic signed [N_W-1:0] n_z,
	output logic                  zero_length
);

	cell_t             chain [NUM_CELLS+1];
	logic  [N_W-1:0]   n_next [3];
	logic              done_q;
	logic  [N_W-1:0]   n_q [3];
	logic              zero_q;
	cell_t             last;

	// Fully pipelined: never refuse a transaction.
	assign busy = 1'b0;

	ncp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.a_x      (a_x),
		.a_y      (a_y),
		.a_z      (a_z),
		.b_x      (b_x),
		.b_y      (b_y),
		.b_z      (b_z),
		.init     (chain[0])
	);

	// Cell k decides bit NORMAL_FRAC_BITS-k, most significant first.
	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		ncp_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.bit_idx (BIT_W'(NORMAL_FRAC_BITS - k)),
			.din     (chain[k]),
			.dout    (chain[k+1])
		);
	end

	assign last = chain[NUM_CELLS];

	// Apply the sign of each cross product component; force zero on a degenerate pair.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (last.zero) begin
				n_next[i] = '0;
			end else if (last.neg[i]) begin
				n_next[i] = -N_W'(last.q[i]);
			end else begin
				n_next[i] = N_W'(last.q[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			n_q[i] <= n_next[i];
		end
		zero_q <= last.zero;
	end

	assign done        = done_q;
	assign n_x         = n_q[0];
	assign n_y         = n_q[1];
	assign n_z         = n_q[2];
	assign zero_length = zero_q;

endmodule

>>> src/ncp_front.sv
// Front end: cross product, magnitudes, squares and squared length.
module ncp_front import ncp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  coord_t a_x,
	input  coord_t a_y,
	input  coord_t a_z,
	input  coord_t b_x,
	input  coord_t b_y,
	input  coord_t b_z,
	output cell_t  init
);

	localparam int C_W = MAG_W + 1;

	logic signed [MAG_W-1:0] pr_s1 [6];
	logic                    v_s1, v_s2, v_s3, v_s4;
	logic [2:0]              neg_s2, neg_s3, neg_s4;
	mag_t                    mag_s2 [3];
	mag_t                    hh_s3 [3], hl_s3 [3], ll_s3 [3];
	logic                    zero_s3, zero_s4;
	sq_t                     m2_s4 [3];
	len_t                    len2_s4;

	logic signed [C_W-1:0]   c [3];
	sq_t                     m2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		c[0] = C_W'(pr_s1[0]) - C_W'(pr_s1[1]);
		c[1] = C_W'(pr_s1[2]) - C_W'(pr_s1[3]);
		c[2] = C_W'(pr_s1[4]) - C_W'(pr_s1[5]);
		for (int i = 0; i < 3; i++) begin
			m2[i] = (SQ_W'(hh_s3[i]) << MAG_W) + (SQ_W'(hl_s3[i]) << (HALF_W + 1))
				+ SQ_W'(ll_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		pr_s1[0] <= a_y * b_z;
		pr_s1[1] <= a_z * b_y;
		pr_s1[2] <= a_z * b_x;
		pr_s1[3] <= a_x * b_z;
		pr_s1[4] <= a_x * b_y;
		pr_s1[5] <= a_y * b_x;
		for (int i = 0; i < 3; i++) begin
			neg_s2[i] <= c[i][C_W-1];
			mag_s2[i] <= c[i][C_W-1] ? MAG_W'(-c[i]) : MAG_W'(c[i]);
			hh_s3[i]  <= mag_s2[i][MAG_W-1:HALF_W] * mag_s2[i][MAG_W-1:HALF_W];
			hl_s3[i]  <= mag_s2[i][MAG_W-1:HALF_W] * mag_s2[i][HALF_W-1:0];
			ll_s3[i]  <= mag_s2[i][HALF_W-1:0] * mag_s2[i][HALF_W-1:0];
			m2_s4[i]  <= m2[i];
		end
		neg_s3  <= neg_s2;
		neg_s4  <= neg_s3;
		zero_s3 <= (mag_s2[0] == '0) && (mag_s2[1] == '0) && (mag_s2[2] == '0);
		zero_s4 <= zero_s3;
		len2_s4 <= LEN_W'(m2[0]) + LEN_W'(m2[1]) + LEN_W'(m2[2]);
	end

	always_comb begin
		init.valid = v_s4;
		init.zero  = zero_s4;
		init.len2  = len2_s4;
		init.neg   = neg_s4;
		for (int i = 0; i < 3; i++) begin
			init.r[i] = RES_W'(m2_s4[i]) << (2 * NORMAL_FRAC_BITS);
			init.p[i] = '0;
			init.q[i] = '0;
		end
	end

endmodule

>>> src/ncp_cell.sv
// One quotient cell: decides one bit of each of the three normal components.
module ncp_cell import ncp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  bit_idx_t bit_idx,
	input  cell_t    din,
	output cell_t    dout
);

	logic [DLT_W-1:0] delta [3];
	logic [2:0]       take;
	logic [BIT_W:0]   sh_p, sh_l;
	cell_t            nxt;
	cell_t            data_q;
	logic             valid_q;

	// Trying bit b raises q^2*len2 by len2*(2*q*2^b + 4^b); keep it while the residue allows.
	always_comb begin
		sh_p = {1'b0, bit_idx} + 1'b1;
		sh_l = {bit_idx, 1'b0};
		nxt  = din;
		for (int i = 0; i < 3; i++) begin
			delta[i] = (DLT_W'(din.p[i]) << sh_p) + (DLT_W'(din.len2) << sh_l);
			take[i]  = DLT_W'(din.r[i]) >= delta[i];
			if (take[i]) begin
				nxt.r[i] = din.r[i] - RES_W'(delta[i]);
				nxt.p[i] = din.p[i] + (PROD_W'(din.len2) << bit_idx);
				nxt.q[i] = din.q[i] | (Q_W'(1) << bit_idx);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	always_comb begin
		dout       = data_q;
		dout.valid = valid_q;
	end

endmodule

>>> tb/normalized_cross_product_test.sv
// Testbench for the normalized cross product pipeline: directed and random vector pairs.
module normalized_cross_product_test;
	import ncp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Expected unit normal of one transaction.
	typedef struct {
		logic signed [N_W-1:0] x;
		logic signed [N_W-1:0] y;
		logic signed [N_W-1:0] z;
		logic                  zl;
	} normal_t;

	localparam coord_t CMAX = coord_t'(24'h7FFFFF);
	localparam coord_t CMIN = coord_t'(24'h800000);
	localparam int     PIPE_CYCLES = 40;

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	coord_t a_x, a_y, a_z, b_x, b_y, b_z;
	logic   done;
	logic signed [N_W-1:0] n_x, n_y, n_z;
	logic   zero_length;

	normal_t pending_normals[$];
	int      errors;

	normalized_cross_product dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
		.done(done), .n_x(n_x), .n_y(n_y), .n_z(n_z), .zero_length(zero_length)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Stop a hung run after far longer than the slowest correct one takes.
	initial begin
		#5ms;
		$display("normalized_cross_product_test: errors");
		$finish;
	end

	// Exact unit normal: cross product in 64-bit integers, then for each component
	// the largest q in [0, 2^30] with q^2 * |c|^2 <= c_i^2 * 2^60, found bit by bit.
	function automatic normal_t unit_normal(coord_t ax, coord_t ay, coord_t az,
			coord_t bx, coord_t by, coord_t bz);
		longint         c[3];
		logic [199:0]   mag[3];
		logic [199:0]   len2;
		logic [199:0]   rhs;
		logic [199:0]   cand;
		logic [199:0]   q;
		logic [N_W-1:0] comp[3];
		normal_t        res;
		c[0] = longint'(ay) * longint'(bz) - longint'(az) * longint'(by);
		c[1] = longint'(az) * longint'(bx) - longint'(ax) * longint'(bz);
		c[2] = longint'(ax) * longint'(by) - longint'(ay) * longint'(bx);
		len2 = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = 200'(c[i] < 0 ? -c[i] : c[i]);
			len2 = len2 + mag[i] * mag[i];
		end
		if (len2 == 0) begin
			res.x = '0;
			res.y = '0;
			res.z = '0;
			res.zl = 1'b1;
			return res;
		end
		for (int i = 0; i < 3; i++) begin
			rhs = (mag[i] * mag[i]) << (2 * NORMAL_FRAC_BITS);
			q = '0;
			for (int b = NORMAL_FRAC_BITS; b >= 0; b--) begin
				cand = q | (200'(1) << b);
				if (cand * cand * len2 <= rhs)
					q = cand;
			end
			comp[i] = c[i] < 0 ? -q[N_W-1:0] : q[N_W-1:0];
		end
		res.x = comp[0];
		res.y = comp[1];
		res.z = comp[2];
		res.zl = 1'b0;
		return res;
	endfunction

	// Gap after a transaction: mostly back to back or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	// Drive one vector pair, hold it until accepted, record its expected normal.
	// Call at a rising edge; start stays high when no gap follows.
	task automatic send_pair(coord_t ax, coord_t ay, coord_t az,
			coord_t bx, coord_t by, coord_t bz, int gap);
		start <= 1'b1;
		a_x <= ax; a_y <= ay; a_z <= az;
		b_x <= bx; b_y <= by; b_z <= bz;
		forever begin
			@(negedge clk);
			if (!busy)
				break;
			@(posedge clk);
		end
		@(posedge clk);
		pending_normals.push_back(unit_normal(ax, ay, az, bx, by, bz));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Compare each strobed result with the oldest expectation, mid-cycle.
	always @(negedge clk) begin
		normal_t want;
		if (arst_n && done) begin
			if (pending_normals.size() == 0) begin
				$display("%0t: result with nothing expected: n=(%0d %0d %0d) zl=%b",
					$time, n_x, n_y, n_z, zero_length);
				errors++;
			end else begin
				want = pending_normals.pop_front();
				if (n_x !== want.x) begin
					$display("%0t: n_x expected %0d got %0d", $time, want.x, n_x);
					errors++;
				end
				if (n_y !== want.y) begin
					$display("%0t: n_y expected %0d got %0d", $time, want.y, n_y);
					errors++;
				end
				if (n_z !== want.z) begin
					$display("%0t: n_z expected %0d got %0d", $time, want.z, n_z);
					errors++;
				end
				if (zero_length !== want.zl) begin
					$display("%0t: zero_length expected %b got %b", $time, want.zl,
						zero_length);
					errors++;
				end
			end
		end
	end

	// Extremes of every field, axis-aligned normals and zero cross products.
	task automatic test_directed();
		send_pair(0, 0, 0, 0, 0, 0, 0);
		send_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1);
		send_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 0);
		send_pair(1, 0, 0, 0, 1, 0, 0);
		send_pair(0, 1, 0, 0, 0, 1, 2);
		send_pair(0, 0, 1, 1, 0, 0, 0);
		send_pair(CMIN, 0, 0, 0, CMIN, 0, 0);
		send_pair(CMAX, 0, 0, 0, CMIN, 0, 3);
		send_pair(0, CMIN, 0, 0, 0, CMAX, 0);
		send_pair(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 0);
		send_pair(CMAX, CMIN, 0, CMIN, CMAX, CMAX, 1);
		send_pair(CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, 0);
		send_pair(-1, -1, -1, 1, -1, 1, 0);
		send_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, 5);
		send_pair(1, 2, 3, 2, 4, 6, 0);
		send_pair(CMAX, 0, 0, 1, 0, 0, 0);
		send_pair(3, 4, 0, 0, 0, 7, 0);
		send_pair(1, 1, 0, 1, -1, 0, 0);
		send_pair(CMIN, 1, 0, 1, CMIN, 0, 0);
		send_pair(CMAX, CMAX, 0, CMAX, -CMAX, 0, 0);
	endtask

	// Random pairs: mostly full range, some small, some parallel or degenerate, some in one coordinate plane.
	task automatic test_random(int count);
		coord_t ax, ay, az, bx, by, bz;
		int     kind, k;
		for (int n = 0; n < count; n++) begin
			ax = coord_t'($urandom);
			ay = coord_t'($urandom);
			az = coord_t'($urandom);
			bx = coord_t'($urandom);
			by = coord_t'($urandom);
			bz = coord_t'($urandom);
			kind = $urandom_range(0, 99);
			if (kind < 20) begin
				// Small components: coarse normals, many exact ties.
				ax = coord_t'(int'($urandom_range(0, 6)) - 3);
				ay = coord_t'(int'($urandom_range(0, 6)) - 3);
				az = coord_t'(int'($urandom_range(0, 6)) - 3);
				bx = coord_t'(int'($urandom_range(0, 6)) - 3);
				by = coord_t'(int'($urandom_range(0, 6)) - 3);
				bz = coord_t'(int'($urandom_range(0, 6)) - 3);
			end else if (kind < 30) begin
				// Parallel: b is a small multiple of a, so the cross product is zero.
				ax = coord_t'(int'($urandom_range(0, 4095)) - 2048);
				ay = coord_t'(int'($urandom_range(0, 4095)) - 2048);
				az = coord_t'(int'($urandom_range(0, 4095)) - 2048);
				k = int'($urandom_range(0, 8)) - 4;
				bx = coord_t'(ax * k);
				by = coord_t'(ay * k);
				bz = coord_t'(az * k);
			end else if (kind < 35) begin
				// One vector is zero.
				if ($urandom_range(0, 1)) begin
					ax = 0; ay = 0; az = 0;
				end else begin
					bx = 0; by = 0; bz = 0;
				end
			end else if (kind < 45) begin
				// Vectors in one coordinate plane: axis-aligned normal.
				az = 0;
				bz = 0;
			end
			send_pair(ax, ay, az, bx, by, bz, pick_gap());
		end
	endtask

	initial begin
		errors = 0;
		arst_n = 1'b0;
		start = 1'b0;
		a_x = '0; a_y = '0; a_z = '0;
		b_x = '0; b_y = '0; b_z = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(1030);

		// Drop start, drain the pipe, then stay idle to catch any stray strobes.
		start <= 1'b0;
		while (pending_normals.size() != 0)
			@(posedge clk);
		repeat (PIPE_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("normalized_cross_product_test: clean");
		else
			$display("normalized_cross_product_test: errors");
		$finish;
	end

endmodule

>>> filelist.f
src/ncp_pkg.sv
src/ncp_front.sv
src/ncp_cell.sv
src/normalized_cross_product.sv
tb/normalized_cross_product_test.sv
